[rtl/tvg_pkg.sv]
// Shared types, constants and the quarter-wave sine table for the torus vertex generator.
`default_nettype none
package tvg_pkg;

  localparam int MAX_SEGMENTS     = 64;
  localparam int MIN_SEGMENTS     = 5;
  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int QTR_DEPTH        = SINE_TABLE_DEPTH / 4;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned ONE_Q30     = 64'd1 << 30;

  typedef logic signed [17:0] trig_t;
  typedef logic signed [34:0] vec_t;
  typedef logic [16:0] qsine_tab_t [0:QTR_DEPTH];

  typedef struct packed {
    logic signed [15:0] w;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } quat_t;

  typedef struct packed {
    logic [30:0]        major_radius;
    logic [30:0]        minor_radius;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    quat_t              quat;
  } req_t;

  typedef struct packed {
    logic [11:0] own_index;
    logic [11:0] succ_index;
    logic [11:0] next_ring_index;
    logic [11:0] prev_succ_index;
  } idx_t;

  // Sine of the quarter-wave fraction rr/DEPTH, Q16, Horner series through y^11.
  function automatic longint unsigned quarter_sine(input longint unsigned rr);
    longint unsigned y, y2, t, s;
    y  = (HALF_PI_Q30 * rr) / SINE_TABLE_DEPTH;
    y2 = (y * y) >> 30;
    t  = ONE_Q30 - y2 / 110;
    t  = ONE_Q30 - ((y2 * t) >> 30) / 72;
    t  = ONE_Q30 - ((y2 * t) >> 30) / 42;
    t  = ONE_Q30 - ((y2 * t) >> 30) / 20;
    t  = ONE_Q30 - ((y2 * t) >> 30) / 6;
    s  = (((y * t) >> 30) + (64'd1 << 13)) >> 14;
    if (s > 64'd65536) s = 64'd65536;
    return s;
  endfunction

  function automatic qsine_tab_t build_qsine();
    qsine_tab_t tab;
    for (int j = 0; j <= QTR_DEPTH; j++) begin
      tab[j] = 17'(quarter_sine(64'(4 * j)));
    end
    return tab;
  endfunction

  localparam qsine_tab_t QSINE_TAB = build_qsine();

  // Full-wave table entry k, folded onto the quarter table.
  function automatic trig_t trig_lookup(input logic [9:0] k);
    logic [8:0] j;
    logic [8:0] jr;
    trig_t      mag;
    j  = {1'b0, k[7:0]};
    jr = 9'(QTR_DEPTH) - j;
    unique case (k[9:8])
      2'd0:    mag = trig_t'(QSINE_TAB[j]);
      2'd1:    mag = trig_t'(QSINE_TAB[jr]);
      2'd2:    mag = -trig_t'(QSINE_TAB[j]);
      default: mag = -trig_t'(QSINE_TAB[jr]);
    endcase
    return mag;
  endfunction

endpackage
`default_nettype wire

[rtl/tvg_angle.sv]
// Index reduction modulo the segment count and table address (index*1024)/segments.
`default_nettype none
module tvg_angle (
  input  logic       clk,
  input  logic       en,
  input  logic [5:0] idx,
  input  logic [6:0] seg,
  output logic [5:0] idx_mod,
  output logic [9:0] k
);
  logic [9:0] mod_r;
  logic [6:0] rem_a, rem_b, rem2;
  logic [7:0] sh_a, sh_b;
  logic [4:0] q_hi_next, q_lo_next, q_hi;

  // Stage 1: restoring reduction, quotient is below sixteen.
  always_comb begin
    mod_r = {4'd0, idx};
    for (int j = 3; j >= 0; j--) begin
      if (mod_r >= ({3'd0, seg} << j)) mod_r = mod_r - ({3'd0, seg} << j);
    end
  end

  // Stage 2: upper five quotient bits.
  always_comb begin
    rem_a = {1'b0, idx_mod};
    sh_a  = '0;
    for (int j = 4; j >= 0; j--) begin
      sh_a = {rem_a, 1'b0};
      if (sh_a >= {1'b0, seg}) begin
        rem_a        = 7'(sh_a - {1'b0, seg});
        q_hi_next[j] = 1'b1;
      end else begin
        rem_a        = sh_a[6:0];
        q_hi_next[j] = 1'b0;
      end
    end
  end

  // Stage 3: lower five quotient bits.
  always_comb begin
    rem_b = rem2;
    sh_b  = '0;
    for (int j = 4; j >= 0; j--) begin
      sh_b = {rem_b, 1'b0};
      if (sh_b >= {1'b0, seg}) begin
        rem_b        = 7'(sh_b - {1'b0, seg});
        q_lo_next[j] = 1'b1;
      end else begin
        rem_b        = sh_b[6:0];
        q_lo_next[j] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      idx_mod <= mod_r[5:0];
      rem2    <= rem_a;
      q_hi    <= q_hi_next;
      k       <= {q_hi, q_lo_next};
    end
  end
endmodule
`default_nettype wire

[rtl/tvg_rotate.sv]
// Quaternion rotation v + 2w(q x v) + 2 q x (q x v), then translate and saturate.
`default_nettype none
module tvg_rotate (
  input  logic               clk,
  input  logic               en,
  input  tvg_pkg::vec_t      vx,
  input  tvg_pkg::vec_t      vy,
  input  tvg_pkg::vec_t      vz,
  input  tvg_pkg::quat_t     q,
  input  logic signed [31:0] px,
  input  logic signed [31:0] py,
  input  logic signed [31:0] pz,
  output logic signed [31:0] ox,
  output logic signed [31:0] oy,
  output logic signed [31:0] oz
);
  import tvg_pkg::*;

  logic signed [51:0] c0, c1, c2;
  logic signed [37:0] a0, a1, a2;
  vec_t               v1x, v1y, v1z;
  quat_t              q1;
  logic signed [31:0] p1x, p1y, p1z, p2x, p2y, p2z;
  logic signed [54:0] b0, b1, b2;
  logic signed [53:0] wa0, wa1, wa2;
  logic signed [57:0] s0_next, s1_next, s2_next, s0, s1, s2;

  function automatic logic signed [31:0] fin(input logic signed [57:0] s,
                                             input logic signed [31:0] p);
    logic signed [43:0] o;
    logic signed [44:0] t;
    o = 44'((s + 58'sd8192) >>> 14);
    t = 45'(o) + 45'(p);
    if (t > 45'sd2147483647)       return 32'sh7fffffff;
    else if (t < -45'sd2147483648) return 32'sh80000000;
    else                           return t[31:0];
  endfunction

  // Stage R1: q x v rounded to Q16.
  assign c0 = q.y * vz - q.z * vy;
  assign c1 = q.z * vx - q.x * vz;
  assign c2 = q.x * vy - q.y * vx;

  // Stage R2: second cross product and the Q30 sum.
  assign b0  = q1.y * a2 - q1.z * a1;
  assign b1  = q1.z * a0 - q1.x * a2;
  assign b2  = q1.x * a1 - q1.y * a0;
  assign wa0 = q1.w * a0;
  assign wa1 = q1.w * a1;
  assign wa2 = q1.w * a2;
  assign s0_next = (58'(v1x) <<< 14) + (58'(wa0) <<< 1) + (58'(b0) <<< 1);
  assign s1_next = (58'(v1y) <<< 14) + (58'(wa1) <<< 1) + (58'(b1) <<< 1);
  assign s2_next = (58'(v1z) <<< 14) + (58'(wa2) <<< 1) + (58'(b2) <<< 1);

  always_ff @(posedge clk) begin
    if (en) begin
      a0  <= 38'((c0 + 52'sd8192) >>> 14);
      a1  <= 38'((c1 + 52'sd8192) >>> 14);
      a2  <= 38'((c2 + 52'sd8192) >>> 14);
      v1x <= vx;
      v1y <= vy;
      v1z <= vz;
      q1  <= q;
      p1x <= px;
      p1y <= py;
      p1z <= pz;
      s0  <= s0_next;
      s1  <= s1_next;
      s2  <= s2_next;
      p2x <= p1x;
      p2y <= p1y;
      p2z <= p1z;
      ox  <= fin(s0, p2x);
      oy  <= fin(s1, p2y);
      oz  <= fin(s2, p2z);
    end
  end
endmodule
`default_nettype wire

[rtl/torus_mesh_vertex_generator.sv]
// Top level of the torus vertex generator: stream ports, config register and pipeline.
//
// Usage: each transfer on the s_axis channel is one vertex request (radii, pose
// position, orientation quaternion, ring and tube index). Each request yields
// exactly one transfer on m_axis carrying the rotated and translated vertex, the
// rotated minor-radius normal and the four mesh indices of its two triangles.
// The segment count must be written by the user (cfg_wr_en/cfg_wr_data) only while
// the block is idle, which it does not enforce; values are clamped to 5..64 on write.
// Throughput: one request per cycle unless the output stalls (see below); the nine
// stages are angle reduction (three divider steps), table lookup, radius products,
// ring products and three rotation stages.
// Reset: rst clears all stage valid bits and sets the segment count to 50.
// Stall: when m_axis_tready is low with a result waiting, the whole pipeline
// holds and s_axis_tready drops; bubbles do not advance past a held result.
`default_nettype none
module torus_mesh_vertex_generator (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wr_en,
  input  logic [6:0]   cfg_wr_data,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // major_radius[30:0], minor_radius[61:31], pos_x[93:62], pos_y[125:94],
  // pos_z[157:126], quat_w[173:158], quat_x[189:174], quat_y[205:190],
  // quat_z[221:206], ring_index[227:222], tube_index[233:228], zero pad
  input  logic [239:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // vertex_x[31:0], vertex_y[63:32], vertex_z[95:64], normal_x[127:96],
  // normal_y[159:128], normal_z[191:160], own_index[203:192],
  // succ_index[215:204], next_ring_index[227:216], prev_succ_index[239:228]
  output logic [239:0] m_axis_tdata
);
  import tvg_pkg::*;

  localparam int STAGES = 9;

  logic [6:0]  seg;
  logic [12:0] seg_sq;
  logic [6:0]  seg_clamped;
  logic        en;
  logic [STAGES:1] vld;

  req_t  req_in;
  req_t  p [1:6];
  idx_t  idx_pipe [3:STAGES];
  logic [5:0]  ring_m, tube_m;
  logic [9:0]  ku, kv;
  logic [11:0] own2;
  logic [12:0] o1, nr1, nxt_c, nring_c, prev_c;

  trig_t su4, cu4, sv4, cv4, cu5, su5;
  logic signed [49:0] p_scv, p_bcu, p_bsu, p_ssv;
  logic signed [33:0] m5, bcu5, bsu5, nl2_5;
  logic signed [51:0] p_mcu, p_msu;
  logic signed [33:0] nl0_c, nl1_c;
  vec_t vl0, vl1, vl2, nl0, nl1, nl2;
  quat_t q6;
  logic signed [31:0] vx9, vy9, vz9, nx9, ny9, nz9;

  // Clamp the segment count as it is written, and keep its square beside it.
  always_comb begin
    if (cfg_wr_data < 7'(MIN_SEGMENTS))      seg_clamped = 7'(MIN_SEGMENTS);
    else if (cfg_wr_data > 7'(MAX_SEGMENTS)) seg_clamped = 7'(MAX_SEGMENTS);
    else                                     seg_clamped = cfg_wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seg    <= 7'd50;
      seg_sq <= 13'd2500;
    end else if (cfg_wr_en) begin
      seg    <= seg_clamped;
      seg_sq <= 13'(seg_clamped) * 13'(seg_clamped);
    end
  end

  // Advance every stage together unless a finished result is held.
  assign en            = m_axis_tready || !vld[STAGES];
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld[STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[STAGES-1:1], s_axis_tvalid};
    end
  end

  assign req_in.major_radius = s_axis_tdata[30:0];
  assign req_in.minor_radius = s_axis_tdata[61:31];
  assign req_in.pos_x        = s_axis_tdata[93:62];
  assign req_in.pos_y        = s_axis_tdata[125:94];
  assign req_in.pos_z        = s_axis_tdata[157:126];
  assign req_in.quat.w       = s_axis_tdata[173:158];
  assign req_in.quat.x       = s_axis_tdata[189:174];
  assign req_in.quat.y       = s_axis_tdata[205:190];
  assign req_in.quat.z       = s_axis_tdata[221:206];

  // Stages 1-3: reduce indices and divide down to table addresses.
  tvg_angle u_ring (
    .clk(clk), .en(en), .idx(s_axis_tdata[227:222]), .seg(seg),
    .idx_mod(ring_m), .k(ku)
  );
  tvg_angle u_tube (
    .clk(clk), .en(en), .idx(s_axis_tdata[233:228]), .seg(seg),
    .idx_mod(tube_m), .k(kv)
  );

  // Mesh indices: own index in stage 2, the wrapped neighbors in stage 3.
  assign o1      = {1'b0, own2} + 13'd1;
  assign nr1     = {1'b0, own2} + 13'(seg);
  assign nxt_c   = (o1 >= seg_sq) ? 13'd0 : o1;
  assign nring_c = (nr1 >= seg_sq) ? (nr1 - seg_sq) : nr1;
  assign prev_c  = (o1 >= 13'(seg)) ? (o1 - 13'(seg)) : (o1 + seg_sq - 13'(seg));

  // Stage 5: radius products, rounded to Q16.
  assign p_scv = $signed({1'b0, p[4].minor_radius}) * cv4;
  assign p_ssv = $signed({1'b0, p[4].minor_radius}) * sv4;
  assign p_bcu = $signed({1'b0, p[4].major_radius}) * cu4;
  assign p_bsu = $signed({1'b0, p[4].major_radius}) * su4;

  // Stage 6: tube offset around the ring.
  assign p_mcu = m5 * cu5;
  assign p_msu = m5 * su5;
  assign nl0_c = 34'((p_mcu + 52'sd32768) >>> 16);
  assign nl1_c = 34'((p_msu + 52'sd32768) >>> 16);

  always_ff @(posedge clk) begin
    if (en) begin
      p[1] <= req_in;
      for (int i = 2; i <= 6; i++) p[i] <= p[i-1];
      own2        <= 12'(13'(ring_m) * 13'(seg) + 13'(tube_m));
      idx_pipe[3] <= '{own_index: own2, succ_index: nxt_c[11:0],
                       next_ring_index: nring_c[11:0],
                       prev_succ_index: prev_c[11:0]};
      for (int i = 4; i <= STAGES; i++) idx_pipe[i] <= idx_pipe[i-1];
      su4   <= trig_lookup(ku);
      cu4   <= trig_lookup(10'(ku + 10'(QTR_DEPTH)));
      sv4   <= trig_lookup(kv);
      cv4   <= trig_lookup(10'(kv + 10'(QTR_DEPTH)));
      m5    <= 34'((p_scv + 50'sd32768) >>> 16);
      nl2_5 <= 34'((p_ssv + 50'sd32768) >>> 16);
      bcu5  <= 34'((p_bcu + 50'sd32768) >>> 16);
      bsu5  <= 34'((p_bsu + 50'sd32768) >>> 16);
      cu5   <= cu4;
      su5   <= su4;
      nl0   <= 35'(nl0_c);
      nl1   <= 35'(nl1_c);
      nl2   <= 35'(nl2_5);
      vl0   <= 35'(bcu5) + 35'(nl0_c);
      vl1   <= 35'(bsu5) + 35'(nl1_c);
      vl2   <= 35'(nl2_5);
      q6    <= p[5].quat;
    end
  end

  // Stages 7-9: rotate the vertex (then translate) and the normal.
  tvg_rotate u_rot_vtx (
    .clk(clk), .en(en), .vx(vl0), .vy(vl1), .vz(vl2), .q(q6),
    .px(p[6].pos_x), .py(p[6].pos_y), .pz(p[6].pos_z),
    .ox(vx9), .oy(vy9), .oz(vz9)
  );
  tvg_rotate u_rot_nrm (
    .clk(clk), .en(en), .vx(nl0), .vy(nl1), .vz(nl2), .q(q6),
    .px(32'sd0), .py(32'sd0), .pz(32'sd0),
    .ox(nx9), .oy(ny9), .oz(nz9)
  );

  assign m_axis_tdata = {idx_pipe[STAGES].prev_succ_index,
                         idx_pipe[STAGES].next_ring_index,
                         idx_pipe[STAGES].succ_index,
                         idx_pipe[STAGES].own_index,
                         nz9, ny9, nx9, vz9, vy9, vx9};
endmodule
`default_nettype wire

[rtl/tvg_checker.sv]
// Port-level checks for the torus vertex generator, bound to the top level.
`default_nettype none
module tvg_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [239:0] m_axis_tdata
);
  // Hold a stalled result unchanged.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // Nothing comes out in the cycle after reset.
  a_rst: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  // An empty output stage never blocks the input.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // A nonzero next index is the own index plus one.
  a_next: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[215:204] != 12'd0)
      |-> m_axis_tdata[215:204] == 12'(m_axis_tdata[203:192] + 12'd1))
    else $error("next index mismatch");
endmodule

bind torus_mesh_vertex_generator tvg_checker u_tvg_checker (.*);
`default_nettype wire

[verif/torus_mesh_vertex_generator_test.sv]
// Self-checking testbench for the torus vertex generator: predicted vertices vs. stream output.
`timescale 1ns / 100ps
module torus_mesh_vertex_generator_test;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_wr_en = 1'b0;
  logic [6:0]   cfg_wr_data = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [239:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [239:0] m_axis_tdata;

  // Segment count as the predictor sees it (raw 7-bit register value).
  logic [6:0]   seg_reg = 7'd50;
  logic [239:0] vertex_queue [$];
  int           fail_count = 0;
  int           sent_count = 0;
  int           got_count = 0;
  bit           rx_long_ok = 1'b1;

  localparam int TABLE_DEPTH = 1024;

  torus_mesh_vertex_generator u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #6 clk = ~clk;

  // Round half up by 2^n using floor semantics of the arithmetic shift.
  function automatic longint round_shift(input longint v, input int n);
    return (v + (longint'(1) << (n - 1))) >>> n;
  endfunction

  function automatic logic [31:0] clip32(input longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  // Horner sine of the quarter-wave fraction rr/DEPTH, Q16.
  function automatic longint sine_quarter(input longint unsigned rr);
    longint unsigned y, y2, t, s;
    y  = (64'd1686629713 * rr) / TABLE_DEPTH;
    y2 = (y * y) >> 30;
    t  = (64'd1 << 30) - y2 / 110;
    t  = (64'd1 << 30) - ((y2 * t) >> 30) / 72;
    t  = (64'd1 << 30) - ((y2 * t) >> 30) / 42;
    t  = (64'd1 << 30) - ((y2 * t) >> 30) / 20;
    t  = (64'd1 << 30) - ((y2 * t) >> 30) / 6;
    s  = (((y * t) >> 30) + (64'd1 << 13)) >> 14;
    if (s > 64'd65536) s = 64'd65536;
    return longint'(s);
  endfunction

  function automatic longint sine_at(input longint unsigned k);
    longint unsigned q4, r;
    q4 = 4 * (k % TABLE_DEPTH);
    r  = q4 % TABLE_DEPTH;
    case (q4 / TABLE_DEPTH)
      0:       return sine_quarter(r);
      1:       return sine_quarter(TABLE_DEPTH - r);
      2:       return -sine_quarter(r);
      default: return -sine_quarter(TABLE_DEPTH - r);
    endcase
  endfunction

  // Rotate a Q16 vector by a Q14 quaternion (w, x, y, z), Q16 result.
  task automatic quat_rotate(input longint q[4], input longint v[3], output longint o[3]);
    longint a[3], b[3];
    a[0] = round_shift(q[2] * v[2] - q[3] * v[1], 14);
    a[1] = round_shift(q[3] * v[0] - q[1] * v[2], 14);
    a[2] = round_shift(q[1] * v[1] - q[2] * v[0], 14);
    b[0] = q[2] * a[2] - q[3] * a[1];
    b[1] = q[3] * a[0] - q[1] * a[2];
    b[2] = q[1] * a[1] - q[2] * a[0];
    for (int i = 0; i < 3; i++) o[i] = round_shift(v[i] * 16384 + 2 * q[0] * a[i] + 2 * b[i], 14);
  endtask

  // Compute the expected output word of one vertex request.
  task automatic predict_vertex(input logic [239:0] req, output logic [239:0] res);
    longint s, big, tiny, ring, tube, ku, kv, su, cu, sv, cv, m, n, own, nxt, nring, prv;
    longint pos[3], q[4], nl[3], vl[3], vr[3], nr[3];
    s = seg_reg;
    if (s < 5) s = 5;
    if (s > 64) s = 64;
    big  = req[30:0];
    tiny = req[61:31];
    pos[0] = longint'($signed(req[93:62]));
    pos[1] = longint'($signed(req[125:94]));
    pos[2] = longint'($signed(req[157:126]));
    q[0] = longint'($signed(req[173:158]));
    q[1] = longint'($signed(req[189:174]));
    q[2] = longint'($signed(req[205:190]));
    q[3] = longint'($signed(req[221:206]));
    ring = longint'(req[227:222]) % s;
    tube = longint'(req[233:228]) % s;
    ku = (((ring * 65536) / s) * TABLE_DEPTH) >> 16;
    kv = (((tube * 65536) / s) * TABLE_DEPTH) >> 16;
    su = sine_at(ku);
    cu = sine_at(ku + TABLE_DEPTH / 4);
    sv = sine_at(kv);
    cv = sine_at(kv + TABLE_DEPTH / 4);
    m = round_shift(tiny * cv, 16);
    nl[0] = round_shift(m * cu, 16);
    nl[1] = round_shift(m * su, 16);
    nl[2] = round_shift(tiny * sv, 16);
    vl[0] = round_shift(big * cu, 16) + nl[0];
    vl[1] = round_shift(big * su, 16) + nl[1];
    vl[2] = nl[2];
    quat_rotate(q, vl, vr);
    quat_rotate(q, nl, nr);
    for (int i = 0; i < 3; i++) begin
      res[32*i +: 32]      = clip32(vr[i] + pos[i]);
      res[96 + 32*i +: 32] = clip32(nr[i]);
    end
    n = s * s;
    own = ring * s + tube;
    nxt = (own + 1 >= n) ? 0 : own + 1;
    nring = (own + s >= n) ? own + s - n : own + s;
    prv = (own + 1 >= s) ? own + 1 - s : own + 1 + n - s;
    res[203:192] = own[11:0];
    res[215:204] = nxt[11:0];
    res[227:216] = nring[11:0];
    res[239:228] = prv[11:0];
  endtask

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len(input bit allow_long);
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93 || !allow_long) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Drop valid only when a gap follows; back-to-back items keep it high.
  task automatic send_request(input logic [239:0] req, input bit idle_ok);
    logic [239:0] res;
    int g;
    g = idle_ok ? gap_len(1'b1) : 0;
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    s_axis_tdata  <= req;
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_vertex(req, res);
    vertex_queue.insert(vertex_queue.size(), res);
    sent_count++;
    @(negedge clk);
  endtask

  function automatic logic [239:0] make_request(
      input logic [30:0] big, input logic [30:0] tiny,
      input logic [31:0] px, input logic [31:0] py, input logic [31:0] pz,
      input logic [63:0] wxyz, input logic [5:0] ring, input logic [5:0] tube);
    // wxyz holds w in the top 16 bits down to z in the low 16.
    return {6'd0, tube, ring, wxyz[15:0], wxyz[31:16], wxyz[47:32], wxyz[63:48],
            pz, py, px, tiny, big};
  endfunction

  function automatic logic [239:0] random_request(input bit unit_quat);
    logic [63:0] q;
    logic [30:0] big, tiny;
    if (unit_quat) begin
      // Pick among four unit quaternions (identity, x, y and diagonal axes), random sign of x.
      case ($urandom_range(0, 3))
        0: q = {16'sd16384, 48'd0};
        1: q = {16'sd11585, 16'sd11585, 32'd0};
        2: q = {16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192};
        default: q = {16'sd0, 16'sd0, 16'sd16384, 16'sd0};
      endcase
      if ($urandom_range(0, 1)) q[47:32] = -$signed(q[47:32]);
    end else begin
      q = {$urandom, $urandom};
    end
    if ($urandom_range(0, 3) == 0) begin
      big = 31'($urandom); tiny = 31'($urandom);
    end else begin
      big  = 31'($urandom_range(0, 32'h00ff_ffff));
      tiny = 31'($urandom_range(0, 32'h003f_ffff));
    end
    return make_request(big, tiny, $urandom, $urandom, $urandom, q,
                        6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
  endfunction

  // Drop valid, wait until every predicted result has been received, then idle before returning.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (vertex_queue.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic write_segments(input logic [6:0] value);
    wait_idle();
    cfg_wr_data <= value;
    cfg_wr_en   <= 1'b1;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    seg_reg      = value;
  endtask

  // Receiver: random backpressure, check each transfer against the oldest prediction.
  always @(negedge clk) begin
    int r;
    r = $urandom_range(0, 99);
    if (rst) m_axis_tready <= 1'b0;
    else if (r < 60) m_axis_tready <= 1'b1;
    else if (r < 97 || !rx_long_ok) m_axis_tready <= 1'b0;
    else begin
      m_axis_tready <= 1'b0;
      repeat ($urandom_range(10, 40)) @(negedge clk);
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    logic [239:0] want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got_count++;
      if (vertex_queue.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, m_axis_tdata);
        fail_count++;
      end else begin
        want = vertex_queue.pop_front();
        for (int f = 0; f < 6; f++)
          if (want[32*f +: 32] != m_axis_tdata[32*f +: 32]) begin
            $display("%0t: field %0d expected %h actual %h", $time, f,
                     want[32*f +: 32], m_axis_tdata[32*f +: 32]);
            fail_count++;
          end
        for (int f = 0; f < 4; f++)
          if (want[192 + 12*f +: 12] != m_axis_tdata[192 + 12*f +: 12]) begin
            $display("%0t: index %0d expected %0d actual %0d", $time, f,
                     want[192 + 12*f +: 12], m_axis_tdata[192 + 12*f +: 12]);
            fail_count++;
          end
      end
    end
  end

  // Field extremes, identity and non-unit quaternions, out-of-range indexes, then random requests.
  task automatic test_directed();
    send_request(make_request('0, '0, '0, '0, '0, {16'sd16384, 48'd0}, 6'd0, 6'd0), 1'b0);
    send_request(make_request('1, '1, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                              {16'sd16384, 48'd0}, 6'd49, 6'd49), 1'b0);
    send_request(make_request('1, '1, 32'h80000000, 32'h80000000, 32'h80000000,
                              {4{16'h8000}}, 6'd63, 6'd63), 1'b0);
    send_request(make_request('1, '1, '0, '0, '0, {4{16'h7fff}}, 6'd12, 6'd37), 1'b0);
    send_request(make_request(31'h0004_0000, 31'h0001_0000, '0, '0, '0,
                              {16'sd0, 16'sd16384, 32'd0}, 6'd0, 6'd49), 1'b0);
    send_request(make_request(31'h0004_0000, 31'h0001_0000, 32'hffff0000, '0, 32'h10000,
                              {16'sd11585, 16'sd0, 16'sd0, 16'sd11585}, 6'd25, 6'd0),
                 1'b0);
    send_request(make_request(31'h0004_0000, 31'h0001_0000, '0, '0, '0,
                              {16'sd0, 16'sd0, 16'sd0, -16'sd16384}, 6'd50, 6'd0), 1'b0);
    for (int i = 0; i < 8; i++) send_request(random_request(i[0]), 1'b1);
  endtask

  task automatic test_segment_sweep();
    logic [6:0] settings [8] = '{7'd5, 7'd64, 7'd0, 7'd127, 7'd4, 7'd65, 7'd7, 7'd33};
    foreach (settings[i]) begin
      write_segments(settings[i]);
      for (int j = 0; j < 25; j++) send_request(random_request($urandom_range(0, 3) != 0), 1'b1);
    end
  endtask

  task automatic test_random_stream();
    for (int p = 0; p < 5; p++) begin
      write_segments(p == 0 ? 7'd50 : 7'($urandom_range(0, 127)));
      rx_long_ok = (p != 2);
      for (int j = 0; j < 100; j++)
        send_request(random_request($urandom_range(0, 3) != 0), p != 3);
    end
    rx_long_ok = 1'b1;
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_segment_sweep();
    test_random_stream();
    wait_idle();
    $display("Sent %0d vertex requests over 14 segment settings, checked %0d results.",
             sent_count, got_count);
    if (fail_count == 0) $display("torus_mesh_vertex_generator_test OK");
    else $display("torus_mesh_vertex_generator_test NOT OK");
    $finish;
  end

  initial begin
    #5ms;
    $display("torus_mesh_vertex_generator_test NOT OK");
    $finish;
  end

endmodule
